### design/u8st_pkg.sv
// ============================================================================
// u8st_pkg - shared types and constants for the utf-8 sanitizer
// Byte codes, lead byte decoding and the burst format passed between the
// front and back parts of the block.
// ============================================================================
package u8st_pkg;

    localparam int MAX_SEQUENCE = 4;
    localparam int PEND_DEPTH   = MAX_SEQUENCE - 1;
    localparam int BURST_BYTES  = MAX_SEQUENCE;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] CAP_RESET   = 8'd64;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_QMARK  = 8'h3f;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam logic [7:0] LEAD2_LO    = 8'hc2;
    localparam logic [7:0] LEAD2_HI    = 8'hdf;
    localparam logic [7:0] LEAD3_LO    = 8'he0;
    localparam logic [7:0] LEAD3_HI    = 8'hef;
    localparam logic [7:0] LEAD4_LO    = 8'hf0;
    localparam logic [7:0] LEAD4_HI    = 8'hf4;
    localparam logic [7:0] LEAD_E0     = 8'he0;
    localparam logic [7:0] LEAD_ED     = 8'hed;
    localparam logic [7:0] LEAD_F0     = 8'hf0;
    localparam logic [7:0] LEAD_F4     = 8'hf4;
    localparam logic [7:0] CONT_A0     = 8'ha0;
    localparam logic [7:0] CONT_90     = 8'h90;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    localparam logic [2:0] LEN_NONE    = 3'd0;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    // results of one input item: data bytes, then an optional terminator
    typedef struct packed {
        logic [BURST_BYTES-1:0][7:0] data;
        logic [2:0]                  count;
        logic                        term;
    } burst_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if (b >= LEAD2_LO && b <= LEAD2_HI)
            len = LEN_TWO;
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
            len = LEN_THREE;
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
            len = LEN_FOUR;
        return len;
    endfunction

endpackage

### design/u8st_front.sv
// ============================================================================
// u8st_front - byte classifier and sequence tracker
// Takes one source byte per cycle unless the queue is full, tracks the open utf-8
// sequence and output budget, and pushes the bytes the item releases as one burst.
// ============================================================================
module u8st_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              cfg_write,
    input  logic [7:0]        cfg_data,
    input  u8st_pkg::q_status_t q_status,
    output logic              q_push,
    output u8st_pkg::burst_t  q_data
);
    import u8st_pkg::*;

    logic [7:0]                  cap_reg;
    logic [PEND_DEPTH-1:0][7:0]  pend_reg, pend_next;
    logic [1:0]                  pcnt_reg, pcnt_next;
    logic [2:0]                  elen_reg, elen_next;
    logic [7:0]                  wcnt_reg, wcnt_next;
    logic                        stopped_reg, stopped_next;

    logic       accept;
    logic [8:0] space;
    logic [2:0] avail;
    logic [2:0] b_len;
    logic       b_lead;
    logic [7:0] b_conv;
    logic       range_ok;
    logic       cont_ok;
    logic       complete;
    logic [2:0] qpre;
    logic [2:0] n_try;
    logic [2:0] emitted;
    logic       seq_mode;
    logic       start;

    assign accept = push && !q_status.full;

    // data bytes still allowed, saturated at one full sequence
    assign space = {1'b0, cap_reg} - {1'b0, wcnt_reg} - 9'd1;
    always_comb
    begin
        if (stopped_reg || cap_reg <= wcnt_reg)
            avail = 3'd0;
        else if (space > 9'd4)
            avail = 3'd4;
        else
            avail = space[2:0];
    end

    assign b_len  = lead_len(in_byte);
    assign b_lead = (b_len != LEN_NONE);
    assign b_conv = !in_byte[7] ? ((in_byte < CHAR_SPACE) ? CHAR_SPACE : in_byte)
                                : CHAR_QMARK;

    // overlong, surrogate and out-of-range checks on the second byte
    always_comb
    begin
        range_ok = 1'b1;
        if (elen_reg == LEN_THREE)
            range_ok = !((pend_reg[0] == LEAD_E0 && in_byte < CONT_A0) ||
                         (pend_reg[0] == LEAD_ED && in_byte >= CONT_A0));
        else if (elen_reg == LEN_FOUR)
            range_ok = !((pend_reg[0] == LEAD_F0 && in_byte < CONT_90) ||
                         (pend_reg[0] == LEAD_F4 && in_byte >= CONT_90));
    end

    assign cont_ok  = (in_byte[7:6] == CONT_TAG) && (pcnt_reg != 2'd1 || range_ok);
    assign complete = ({1'b0, pcnt_reg} + 3'd1) >= elen_reg;

    always_comb
    begin
        qpre         = 3'd0;
        n_try        = 3'd0;
        seq_mode     = 1'b0;
        start        = 1'b0;
        pend_next    = pend_reg;
        pcnt_next    = pcnt_reg;
        elen_next    = elen_reg;
        stopped_next = stopped_reg;

        if (pcnt_reg == 2'd0)
        begin
            if (b_lead)
            begin
                if (avail != 3'd0)
                begin
                    start = 1'b1;
                    n_try = {2'b00, in_last};
                end
            end
            else
                n_try = 3'd1;
        end
        else if (!cont_ok)
        begin
            // lead and buffered continuations become '?', then the byte is retried
            qpre      = {1'b0, pcnt_reg};
            pcnt_next = 2'd0;
            elen_next = LEN_NONE;
            if (b_lead)
            begin
                if (avail > {1'b0, pcnt_reg})
                begin
                    start = 1'b1;
                    n_try = {1'b0, pcnt_reg} + {2'b00, in_last};
                end
                else
                    n_try = {1'b0, pcnt_reg};
            end
            else
                n_try = {1'b0, pcnt_reg} + 3'd1;
        end
        else if (complete)
        begin
            pcnt_next = 2'd0;
            elen_next = LEN_NONE;
            if (avail >= elen_reg)
            begin
                seq_mode = 1'b1;
                n_try    = elen_reg;
            end
            else
                stopped_next = 1'b1;
        end
        else
        begin
            pend_next[pcnt_reg] = in_byte;
            pcnt_next           = pcnt_reg + 2'd1;
            // open sequence cut off by the end of the string
            n_try = in_last ? ({1'b0, pcnt_reg} + 3'd1) : 3'd0;
        end

        if (start)
        begin
            pend_next[0] = in_byte;
            pcnt_next    = 2'd1;
            elen_next    = b_len;
        end

        emitted   = (n_try < avail) ? n_try : avail;
        wcnt_next = wcnt_reg + {5'b00000, emitted};

        if (in_last)
        begin
            pcnt_next    = 2'd0;
            elen_next    = LEN_NONE;
            wcnt_next    = 8'd0;
            stopped_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < BURST_BYTES; i++)
            q_data.data[i] = (3'(i) < qpre) ? CHAR_QMARK : b_conv;
        if (seq_mode)
        begin
            q_data.data[0] = pend_reg[0];
            q_data.data[1] = (pcnt_reg > 2'd1) ? pend_reg[1] : in_byte;
            q_data.data[2] = (pcnt_reg > 2'd2) ? pend_reg[2] : in_byte;
            q_data.data[3] = in_byte;
        end
        q_data.count = emitted;
        q_data.term  = in_last;
    end

    assign q_push = accept && (emitted != 3'd0 || in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            pcnt_reg    <= 2'd0;
            elen_reg    <= LEN_NONE;
            wcnt_reg    <= 8'd0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                cap_reg <= cfg_data;
            if (accept)
            begin
                pcnt_reg    <= pcnt_next;
                elen_reg    <= elen_next;
                wcnt_reg    <= wcnt_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= pend_next;
    end

endmodule

### design/u8st_queue.sv
// ============================================================================
// u8st_queue - burst queue between front and back, a small circular buffer
// One burst is written per cycle unless full and one read unless empty.
// ============================================================================
module u8st_queue #(
    parameter int DEPTH = u8st_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  u8st_pkg::burst_t    wr_data,
    input  logic                rd_en,
    output u8st_pkg::burst_t    rd_data,
    output u8st_pkg::q_status_t status
);
    import u8st_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    burst_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### design/u8st_back.sv
// ============================================================================
// u8st_back - burst serializer
// Holds the burst at the head of the queue and hands out its bytes one per
// pop, the terminator last, loading the next burst as the current one ends.
// ============================================================================
module u8st_back (
    input  logic                clk,
    input  logic                rst_n,
    input  u8st_pkg::q_status_t q_status,
    input  u8st_pkg::burst_t    q_data,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    import u8st_pkg::*;

    burst_t     cur_reg;
    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [2:0] len;
    logic       take;
    logic       finish;

    assign len    = cur_reg.count + {2'b00, cur_reg.term};
    assign take   = valid_reg && pop;
    assign finish = take && (idx_reg + 3'd1 == len);
    assign q_pop  = (!valid_reg || finish) && !q_status.empty;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
        end
        else if (finish)
            valid_next = 1'b0;
        else if (take)
            idx_next = idx_reg + 3'd1;
    end

    assign empty    = !valid_reg;
    assign out_byte = (idx_reg < cur_reg.count) ? cur_reg.data[idx_reg[1:0]] : CHAR_NUL;
    assign out_last = (idx_reg == cur_reg.count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

endmodule

### design/utf8_sanitize_truncate.sv
// ============================================================================
// utf8_sanitize_truncate - bounded utf-8 sanitizing string copier
// Cleans a byte string and appends a terminating zero byte.
// ============================================================================
// One source byte is accepted per cycle while full is low. The front part
// decides in that cycle every byte the item releases (up to four data bytes
// plus the terminator on the final item) and writes them as one burst into a
// QUEUE_DEPTH-entry queue; the back part hands out one result per cycle while
// pop is high, so an item that releases n results needs n pops, and the
// sustained input rate is one item per cycle whenever pop stays high and the
// average result count per item stays at or below one. Control bytes become
// spaces, bad sequences have every byte replaced by '?', and output_capacity
// (write through cfg_write/cfg_data, reset 64) bounds the data bytes per string
// to capacity minus one. Write the capacity only while no item is in flight; a
// change between the items of one string takes effect at once.
// ============================================================================
module utf8_sanitize_truncate #(
    parameter int QUEUE_DEPTH = u8st_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data
);
    import u8st_pkg::*;

    q_status_t q_stat;
    burst_t    q_wr_data;
    burst_t    q_rd_data;
    logic      q_push;
    logic      q_pop;

    u8st_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data),
        .q_status (q_stat),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    u8st_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data(q_wr_data),
        .rd_en  (q_pop),
        .rd_data(q_rd_data),
        .status (q_stat)
    );

    u8st_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_status(q_stat),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .out_byte(out_byte),
        .out_last(out_last)
    );

    assign full = q_stat.full;

    // data bytes are never control codes
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_last |-> out_byte >= CHAR_SPACE)
        else $error("control byte on output");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_last |-> out_byte == CHAR_NUL)
        else $error("terminator is not a zero byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("burst written into a full queue");

endmodule
